/* hdl/unsigned_to_ascii_radix_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the radix converter
// Concurrent checks on clk with a synchronous active-high reset named rst.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_ASCII_RADIX_TOP_MACROS_SVH
`define UNSIGNED_TO_ASCII_RADIX_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define U2A_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define U2A_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define U2A_ASSERT_IMP(lbl, ante, cons, msg)
`define U2A_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/u2a_pkg.sv */
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared codes, widths, control structs and the digit glyph function.
// ----------------------------------------------------------------------------
`default_nettype none

package u2a_pkg;

  localparam int KIND_W    = 2;
  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 7;
  localparam int CNT_OUT_W = 4;
  localparam int M_TDATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_DEC    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OCT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HEX_LO = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HEX_UP = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take a new value and kind
    logic shift;  // one double-dabble step
    logic latch;  // capture the digit count
    logic fetch;  // load the next digit into the output register
  } u2a_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_dec;  // incoming word asks for decimal
    logic out_last;  // output register holds the final digit
  } u2a_status_t;

  function automatic logic [CHAR_W-1:0] u2a_glyph(input logic [DIGIT_W-1:0] d,
                                                  input logic upper);
    return (d < DIGIT_W'(10)) ? CHAR_ZERO + CHAR_W'(d)
         : (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(d) - CHAR_W'(10);
  endfunction

endpackage

`default_nettype wire

/* hdl/u2a_datapath.sv */
// ----------------------------------------------------------------------------
// u2a_datapath
// Digit register file, double-dabble shifter, leading-digit search and the
// registered output digit.
// ----------------------------------------------------------------------------
`default_nettype none

module u2a_datapath
  import u2a_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                      clk,
  input  wire  [VALUE_WIDTH-1:0]   value_in,
  input  wire  [KIND_W-1:0]        kind_in,
  input  wire  u2a_cmd_t           cmd,
  output u2a_status_t              status,
  output logic [CHAR_W-1:0]        out_char,
  output logic                     out_last,
  output logic [CNT_OUT_W-1:0]     out_count
);

  localparam int SLOTS = (VALUE_WIDTH + 2) / 3;
  localparam int PAD_W = 4 * SLOTS;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int IW    = $clog2(SLOTS);

  logic [VALUE_WIDTH-1:0] shreg;
  logic                   upper;
  logic [DIGIT_W-1:0]     digits      [SLOTS];
  logic [DIGIT_W-1:0]     load_digits [SLOTS];
  logic [DIGIT_W-1:0]     adj         [SLOTS];
  logic [DIGIT_W-1:0]     step        [SLOTS];
  logic [PAD_W-1:0]       padded;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [IW-1:0]          idx;

  assign padded = PAD_W'(value_in);

  // Octal and hex digits are plain bit groups; decimal starts from zero and
  // is built by the shift loop.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      if (kind_in == KIND_DEC) begin
        load_digits[i] = '0;
      end else if (kind_in == KIND_OCT) begin
        load_digits[i] = {1'b0, padded[3*i +: 3]};
      end else begin
        load_digits[i] = padded[4*i +: 4];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      adj[i] = (digits[i] >= DIGIT_W'(5)) ? digits[i] + DIGIT_W'(3) : digits[i];
    end
    step[0] = {adj[0][2:0], shreg[VALUE_WIDTH-1]};
    for (int i = 1; i < SLOTS; i++) begin
      step[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  // Highest nonzero digit sets the count; zero still yields one digit.
  always_comb begin
    count_next = CW'(1);
    for (int i = 0; i < SLOTS; i++) begin
      if (digits[i] != '0) begin
        count_next = CW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg  <= value_in;
      upper  <= (kind_in == KIND_HEX_UP);
      digits <= load_digits;
    end else if (cmd.shift) begin
      shreg  <= {shreg[VALUE_WIDTH-2:0], 1'b0};
      digits <= step;
    end
    if (cmd.latch) begin
      count <= count_next;
      idx   <= IW'(count_next - CW'(1));
    end
    if (cmd.fetch) begin
      out_char  <= u2a_glyph(digits[idx], upper);
      out_last  <= (idx == '0);
      out_count <= (idx == '0) ? CNT_OUT_W'(count) : '0;
      idx       <= idx - IW'(1);
    end
  end

  assign status.load_dec = (kind_in == KIND_DEC);
  assign status.out_last = out_last;

endmodule

`default_nettype wire

/* hdl/u2a_ctrl.sv */
// ----------------------------------------------------------------------------
// u2a_ctrl
// Sequencer: accept, decimal shift loop, count capture, digit emission.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unsigned_to_ascii_radix_top_macros.svh"

module u2a_ctrl
  import u2a_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  wire         out_ready,
  output u2a_cmd_t    cmd,
  input  wire  u2a_status_t status
);

  localparam int BW = $clog2(VALUE_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_COUNT,
    ST_FETCH,
    ST_EMIT
  } state_t;

  state_t        state;
  logic [BW-1:0] bitcnt;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.load  = (state == ST_IDLE) && in_valid;
    cmd.shift = (state == ST_CONVERT);
    cmd.latch = (state == ST_COUNT);
    cmd.fetch = (state == ST_FETCH) ||
                ((state == ST_EMIT) && out_ready && !status.out_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bitcnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            bitcnt <= BW'(VALUE_WIDTH - 1);
            state  <= status.load_dec ? ST_CONVERT : ST_COUNT;
          end
        end
        ST_CONVERT: begin
          if (bitcnt == '0) begin
            state <= ST_COUNT;
          end else begin
            bitcnt <= bitcnt - BW'(1);
          end
        end
        ST_COUNT: begin
          state <= ST_FETCH;
        end
        ST_FETCH: begin
          out_valid <= 1'b1;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_ready && status.out_last) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

  `U2A_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "input taken while digits pending")
  `U2A_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready, "second word taken early")
  `U2A_ASSERT_NXT(a_last_idle, out_valid && out_ready && status.out_last,
                  in_ready && !out_valid, "no return to idle after final digit")
  `U2A_ASSERT_NXT(a_loop_end, (state == ST_CONVERT) && (bitcnt == '0),
                  state == ST_COUNT, "shift loop overran")

endmodule

`default_nettype wire

/* hdl/unsigned_to_ascii_radix_top.sv */
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_top
// Converts an unsigned value to ASCII digits in decimal, octal or hex,
// most significant digit first, with no leading zeros.
//
// Port group       Dir  Contents
// s_axis_*         in   tdata: value; tuser: kind
// m_axis_*         out  tdata: char_code, digit_count; tlast: final digit
//
// One value at a time. Decimal runs the double-dabble loop first, one value
// bit per cycle; octal and hex skip it and go straight to the count capture.
// Digits then leave at one word per cycle while m_axis_tready is high.
// A new value is taken only after the final digit's word is accepted.
// Reset returns the sequencer to idle; digit registers need no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_to_ascii_radix_top
  import u2a_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [((VALUE_WIDTH + 7) / 8)*8-1:0] s_axis_tdata,  // value
  input  wire  [KIND_W-1:0]                   s_axis_tuser,  // kind
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [M_TDATA_W-1:0]                m_axis_tdata,  // char_code, digit_count
  output logic                                m_axis_tlast
);

  u2a_cmd_t            cmd;
  u2a_status_t         status;
  logic [CHAR_W-1:0]   out_char;
  logic [CNT_OUT_W-1:0] out_count;

  u2a_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  u2a_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .value_in (s_axis_tdata[VALUE_WIDTH-1:0]),
    .kind_in  (s_axis_tuser),
    .cmd      (cmd),
    .status   (status),
    .out_char (out_char),
    .out_last (m_axis_tlast),
    .out_count(out_count)
  );

  assign m_axis_tdata = {{(M_TDATA_W - CHAR_W - CNT_OUT_W){1'b0}}, out_count, out_char};

endmodule

`default_nettype wire

/* bench/unsigned_to_ascii_radix_top_tb.sv */
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_top_tb
// Feeds values and radix kinds into the converter and checks every digit word
// against the table text or a digit predictor. A short directed table covers
// zero, the largest value and both hex cases. Random values of every length
// follow under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module unsigned_to_ascii_radix_top_tb;
  import u2a_pkg::*;

  localparam int VALUE_WIDTH   = 32;
  localparam int DATA_W        = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int MAX_DIGITS    = 11;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = VALUE_WIDTH + 30;
  localparam int RANDOM_ITEMS  = 120;
  localparam int DIRECTED_ROWS = 20;

  typedef struct packed {
    logic [CHAR_W-1:0]    char_code;
    logic                 last;
    logic [CNT_OUT_W-1:0] digit_count;
  } digit_word_t;

  // A zero text means the digits come from the predictor.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [KIND_W-1:0]      kind;
    logic [8*MAX_DIGITS-1:0] text;
  } radix_row_t;

  localparam radix_row_t RADIX_TABLE [DIRECTED_ROWS] = '{
    '{32'd0,          KIND_DEC,    "0"},
    '{32'd0,          KIND_OCT,    "0"},
    '{32'd0,          KIND_HEX_LO, "0"},
    '{32'd0,          KIND_HEX_UP, "0"},
    '{32'hFFFF_FFFF,  KIND_DEC,    "4294967295"},
    '{32'hFFFF_FFFF,  KIND_OCT,    "37777777777"},
    '{32'hFFFF_FFFF,  KIND_HEX_LO, "ffffffff"},
    '{32'hFFFF_FFFF,  KIND_HEX_UP, "FFFFFFFF"},
    '{32'd9,          KIND_DEC,    "9"},
    '{32'd10,         KIND_DEC,    "10"},
    '{32'd7,          KIND_OCT,    "7"},
    '{32'd8,          KIND_OCT,    "10"},
    '{32'd15,         KIND_HEX_LO, "f"},
    '{32'd16,         KIND_HEX_UP, "10"},
    '{32'h00AB_CDEF,  KIND_HEX_LO, "abcdef"},
    '{32'h00AB_CDEF,  KIND_HEX_UP, "ABCDEF"},
    '{32'h8000_0000,  KIND_OCT,    "20000000000"},
    '{32'd1000000000, KIND_DEC,    '0},
    '{32'h1234_5678,  KIND_HEX_UP, '0},
    '{32'd1234567,    KIND_OCT,    '0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;   // value
  logic [KIND_W-1:0]    s_axis_tuser = '0;   // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // char_code, digit_count
  logic                 m_axis_tlast;

  digit_word_t pending_digits[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  unsigned_to_ascii_radix_top #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL unsigned_to_ascii_radix_top");
      $finish;
    end
  end

  // Queues the digit words of one value, most significant digit first.
  function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] value,
                                         input logic [KIND_W-1:0] kind);
    logic [VALUE_WIDTH-1:0] rest;
    logic [VALUE_WIDTH-1:0] radix;
    logic [DIGIT_W-1:0]     digits [24];
    logic [CHAR_W-1:0]      glyph;
    digit_word_t            word;
    int                     count;
    rest  = value;
    count = 0;
    case (kind)
      KIND_DEC: radix = 10;
      KIND_OCT: radix = 8;
      default:  radix = 16;
    endcase
    do begin
      digits[count] = DIGIT_W'(rest % radix);
      count++;
      rest = rest / radix;
    end while (rest != 0);
    for (int k = count - 1; k >= 0; k--) begin
      if (digits[k] < 10) begin
        glyph = CHAR_ZERO + CHAR_W'(digits[k]);
      end else begin
        glyph = ((kind == KIND_HEX_UP) ? CHAR_UPPER_A : CHAR_LOWER_A)
              + CHAR_W'(digits[k]) - CHAR_W'(10);
      end
      word.char_code   = glyph;
      word.last        = (k == 0);
      word.digit_count = (k == 0) ? CNT_OUT_W'(count) : '0;
      pending_digits.push_back(word);
    end
  endfunction

  // Queues the digit words spelled out by a right-aligned text from the table.
  function automatic void queue_text(input logic [8*MAX_DIGITS-1:0] text);
    digit_word_t word;
    int          total;
    int          seen;
    total = 0;
    seen  = 0;
    for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
      if (text[i*8 +: 8] != 8'd0) total++;
    end
    for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
      if (text[i*8 +: 8] != 8'd0) begin
        seen++;
        word.char_code   = text[i*8 +: CHAR_W];
        word.last        = (seen == total);
        word.digit_count = (seen == total) ? CNT_OUT_W'(total) : '0;
        pending_digits.push_back(word);
      end
    end
  endfunction

  // Offers one value, after a random gap or after the output has drained.
  task automatic send_value(input logic [VALUE_WIDTH-1:0] value,
                            input logic [KIND_W-1:0] kind,
                            input logic [8*MAX_DIGITS-1:0] text,
                            input bit drain_first);
    int gap;
    gap = 0;
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) gap++;
    end
    if (gap > 0 || drain_first) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain_first && pending_digits.size() != 0) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'(value);
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    if (text != '0) begin
      queue_text(text);
    end else begin
      predict_digits(value, kind);
    end
  endtask

  always @(posedge clk) begin
    digit_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected word: char %h last %b count %0d", $time,
                 m_axis_tdata[CHAR_W-1:0], m_axis_tlast,
                 m_axis_tdata[CHAR_W +: CNT_OUT_W]);
        mismatch_count++;
      end else begin
        want = pending_digits.pop_front();
        if (m_axis_tdata[CHAR_W-1:0] !== want.char_code ||
            m_axis_tlast !== want.last ||
            m_axis_tdata[CHAR_W +: CNT_OUT_W] !== want.digit_count) begin
          $display("%0t: expected char %h last %b count %0d, got char %h last %b count %0d",
                   $time, want.char_code, want.last, want.digit_count,
                   m_axis_tdata[CHAR_W-1:0], m_axis_tlast,
                   m_axis_tdata[CHAR_W +: CNT_OUT_W]);
          mismatch_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int send_pcts [4];
    int stall_pcts [4];
    int bits;
    logic [VALUE_WIDTH-1:0] value;
    send_pcts  = '{0, 79, 0, 35};
    stall_pcts = '{0, 0, 79, 35};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_value(RADIX_TABLE[r].value, RADIX_TABLE[r].kind, RADIX_TABLE[r].text, 1'b0);
    end

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pcts[phase];
      recv_stall_pct = stall_pcts[phase];
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        // Random lengths keep short numbers as common as full-width ones.
        bits  = $urandom_range(VALUE_WIDTH, 0);
        value = (bits == 0) ? '0 : VALUE_WIDTH'($urandom >> (32 - bits));
        send_value(value, KIND_W'($urandom_range(3)), '0,
                   (phase == 2 && n == RANDOM_ITEMS / 2));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS unsigned_to_ascii_radix_top");
    end else begin
      $display("FAIL unsigned_to_ascii_radix_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
